// File: src/hee_pkg.sv
// Shared types, character codes and the escape builder for the HTML escape encoder.
// No dependencies; every other file refers to this package by scoped names.
package hee_pkg;

	// Queue depth between the classifier and the serializer
	localparam int QUEUE_DEPTH = 2;

	// Longest expansion of one input byte
	localparam int MAX_RUN = 6;
	localparam int RUN_W   = $clog2(MAX_RUN + 1);
	localparam int IDX_W   = $clog2(MAX_RUN);

	// Character codes
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_9     = 8'h39;

	// Last control byte and first high byte
	localparam logic [7:0] CTRL_MAX = 8'd31;
	localparam logic [7:0] HIGH_MIN = 8'd127;

	// Reciprocal of ten for values below one hundred: (v * 103) >> 10
	localparam logic [6:0] RECIP10  = 7'd103;

	typedef enum logic [2:0] {
		CLS_PASS,
		CLS_NAMED,
		CLS_DEC2,
		CLS_DEC3
	} cls_t;

	// One expanded item: text[0] goes out first
	typedef struct packed {
		logic [RUN_W-1:0]         len;
		logic [MAX_RUN-1:0][7:0]  text;
	} desc_t;

	// Head of the queue as seen by the serializer
	typedef struct packed {
		logic  valid;
		desc_t desc;
	} qhead_t;

	// Classify one byte
	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		case (b) inside
			CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_SPACE: c = CLS_NAMED;
			[8'd0:CTRL_MAX], CH_SLASH, CH_SEMI, CH_BSL:       c = CLS_DEC2;
			[HIGH_MIN:8'd255]:                                c = CLS_DEC3;
			default:                                          c = CLS_PASS;
		endcase
		return c;
	endfunction

	// Build the escaped text of one byte
	function automatic desc_t build_desc(input logic [7:0] b);
		desc_t      d;
		logic [1:0] hund;
		logic [6:0] rem;
		logic [13:0] prod;
		logic [3:0] tens;
		logic [3:0] ones;
		logic [7:0] dh;
		logic [7:0] dt;
		logic [7:0] d1;
		hund = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
		rem  = 7'(b - 8'(hund) * 8'd100);
		prod = 14'(rem) * 14'(RECIP10);
		tens = prod[13:10];
		ones = 4'(rem - 7'(tens) * 7'd10);
		dh   = CH_ZERO + 8'(hund);
		dt   = CH_ZERO + 8'(tens);
		d1   = CH_ZERO + 8'(ones);
		d.text = '0;
		d.len  = RUN_W'(1);
		case (classify(b))
			CLS_NAMED: begin
				d.text[0] = CH_AMP;
				case (b)
					CH_AMP: begin
						d.text[1] = CH_A; d.text[2] = CH_M; d.text[3] = CH_P;
						d.text[4] = CH_SEMI; d.len = RUN_W'(5);
					end
					CH_LT: begin
						d.text[1] = CH_L; d.text[2] = CH_T; d.text[3] = CH_SEMI;
						d.len = RUN_W'(4);
					end
					CH_GT: begin
						d.text[1] = CH_G; d.text[2] = CH_T; d.text[3] = CH_SEMI;
						d.len = RUN_W'(4);
					end
					CH_QUOT: begin
						d.text[1] = CH_HASH; d.text[2] = CH_3; d.text[3] = CH_4;
						d.text[4] = CH_SEMI; d.len = RUN_W'(5);
					end
					CH_APOS: begin
						d.text[1] = CH_HASH; d.text[2] = CH_3; d.text[3] = CH_9;
						d.text[4] = CH_SEMI; d.len = RUN_W'(5);
					end
					default: begin
						d.text[1] = CH_N; d.text[2] = CH_B; d.text[3] = CH_S;
						d.text[4] = CH_P; d.text[5] = CH_SEMI; d.len = RUN_W'(6);
					end
				endcase
			end
			CLS_DEC2: begin
				d.text[0] = CH_AMP; d.text[1] = CH_HASH; d.text[2] = dt;
				d.text[3] = d1; d.text[4] = CH_SEMI; d.len = RUN_W'(5);
			end
			CLS_DEC3: begin
				d.text[0] = CH_AMP; d.text[1] = CH_HASH; d.text[2] = dh;
				d.text[3] = dt; d.text[4] = d1; d.text[5] = CH_SEMI;
				d.len = RUN_W'(6);
			end
			default: begin
				d.text[0] = b;
			end
		endcase
		return d;
	endfunction

endpackage

// File: src/hee_front.sv
// Front end of the HTML escape encoder: accepts input words and classifies
// them into expanded descriptors. Depends on hee_pkg.
module hee_front (
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           in_byte,
	input  logic                 q_full,
	output logic                 push,
	output hee_pkg::desc_t       push_desc
);

	// Hold the input while the queue has no room
	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

	// Expand the byte into its escaped text
	always_comb begin
		push_desc = hee_pkg::build_desc(in_byte);
	end

endmodule

// File: src/hee_queue.sv
// Short descriptor queue between front and back of the HTML escape encoder.
// Depends on hee_pkg.
module hee_queue #(
	parameter int QDEPTH = hee_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hee_pkg::desc_t       push_desc,
	input  logic                 pop,
	output logic                 full,
	output logic [$clog2(QDEPTH+1)-1:0] count,
	output hee_pkg::qhead_t      head
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	hee_pkg::desc_t  entry_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(QDEPTH));
	assign count      = count_q;
	assign head.valid = (count_q != '0);
	assign head.desc  = entry_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

// File: src/hee_back.sv
// Back end of the HTML escape encoder: serializes the head descriptor into
// output words through an output register. Depends on hee_pkg.
module hee_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hee_pkg::qhead_t      head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 last_of_run
);

	logic [hee_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      last_q;
	logic                      load;
	logic                      at_last;

	// Load the output register when it is empty or being taken
	assign load    = ~out_valid_q | ~out_stall;
	assign at_last = (hee_pkg::RUN_W'(idx_q) == head.desc.len - hee_pkg::RUN_W'(1));
	assign pop     = load & head.valid & at_last;

	// Step through the run and drop the head on its last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head.valid;
			if (head.valid) begin
				idx_q <= at_last ? '0 : idx_q + hee_pkg::IDX_W'(1);
			end
		end
	end

	// Capture the output word
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.desc.text[idx_q];
			last_q     <= at_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

endmodule

// File: src/html_escape_byte_encoder.sv
// HTML escape encoder: each input byte expands to one to six output words.
// An accepted input byte passes through the descriptor queue and then the output register.
// Throughput: one output word per cycle while out_stall is low, set by the single output register;
// an input byte of n output words takes n of those output slots.
// Reset clears the queue and output valid; no clearing pass, ready at once.
module html_escape_byte_encoder #(
	parameter int QDEPTH = hee_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic                        q_full;
	logic                        push;
	logic                        pop;
	logic [$clog2(QDEPTH+1)-1:0] q_count;
	hee_pkg::desc_t              push_desc;
	hee_pkg::qhead_t             head;

	// Classify incoming words
	hee_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	// Buffer descriptors
	hee_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.count     (q_count),
		.head      (head)
	);

	// Serialize runs
	hee_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	// A taken word that is not the end of its run is followed by more of it
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("run broken before its last word");

	// An accepted input word lands in the queue
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> q_count != '0)
		else $error("accepted word missing from queue");

	// A semicolon only ever closes a run
	a_semi_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == hee_pkg::CH_SEMI |-> last_of_run)
		else $error("semicolon inside a run");

endmodule
